// ===== design/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types, widths and command codes for the sorted delay timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CMD_W       = 2;
	localparam int TASK_W      = 7;
	localparam int TIME_W      = 32;

	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELAY    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNTIL    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_GET_TIME = 2'd3;

	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		logic [TIME_W-1:0] deadline;
	} entry_t;

	// per-cycle instruction broadcast to every cell of the chain
	typedef struct packed {
		logic   insert;
		logic   shift;
		entry_t new_entry;
	} cell_ctl_t;

	// signed a <= b on raw 32-bit words
	function automatic logic le_signed(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		return $signed(a) <= $signed(b);
	endfunction

endpackage

// ===== design/sorted_delay_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_delay_timer_queue
// Tick counter with a deadline-sorted chain of waiting task ids.
// ----------------------------------------------------------------------------
// Sequence: an accepted item moves to CALC; get time answers from CALC, a
// delay answers (or is queued) from DECIDE, and a tick releases its wakeups
// from RELEASE. busy is high from acceptance until the block is back in IDLE;
// wakeups stream one per cycle from the head of the chain. The receiver
// cannot stall, so nothing waits on it.
// Reset (arst_n low): time and entry count cleared, block idle; slots hold
// no meaningful data until written.
// ----------------------------------------------------------------------------
module sorted_delay_timer_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [sdtq_pkg::CMD_W-1:0]  command,
	input  logic [sdtq_pkg::TASK_W-1:0] task_id,
	input  logic signed [sdtq_pkg::TIME_W-1:0] tick_value,
	output logic                        result_strobe,
	output logic [sdtq_pkg::TASK_W-1:0] reply_task,
	output logic signed [sdtq_pkg::TIME_W-1:0] reply_value,
	output logic                        rejected_full,
	output logic                        last_reply
);
	import sdtq_pkg::*;

	// sequencer: IDLE takes an item, CALC does the add, DECIDE compares and
	// inserts, RELEASE pops expired entries from the head, one per cycle
	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_CALC    = 2'd1;
	localparam logic [1:0] ST_DECIDE  = 2'd2;
	localparam logic [1:0] ST_RELEASE = 2'd3;

	logic [1:0]        state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [TASK_W-1:0] task_q;
	logic [TIME_W-1:0] value_q;
	logic [TIME_W-1:0] deadline_q;
	logic [TIME_W-1:0] time_q;
	logic [CNT_W-1:0]  count_q;

	// registered result port
	logic              strobe_q;
	logic [TASK_W-1:0] rtask_q;
	logic [TIME_W-1:0] rvalue_q;
	logic              rfull_q;
	logic              rlast_q;

	// the chain
	cell_ctl_t                 ctl;
	entry_t                    cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]    cell_take;
	logic [QUEUE_DEPTH-1:0]    cell_valid;
	entry_t                    second_entry;
	logic                      second_valid;

	logic passed;     // deadline at or before now: answer at once
	logic full;
	logic head_rel;   // head entry expires at the current time
	logic next_rel;   // ...and the one behind it too

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign reply_task    = rtask_q;
	assign reply_value   = rvalue_q;
	assign rejected_full = rfull_q;
	assign last_reply    = rlast_q;

	assign passed = le_signed(deadline_q, time_q);
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));

	// a slot is occupied when it sits below the fill count
	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			entry_t prev_e;
			entry_t next_e;
			logic   prev_t;

			assign cell_valid[g] = (CNT_W'(g) < count_q);

			if (g == 0) begin : g_head
				assign prev_e = '0;
				assign prev_t = 1'b0;
			end else begin : g_body
				assign prev_e = cell_entry[g-1];
				assign prev_t = cell_take[g-1];
			end

			if (g == QUEUE_DEPTH - 1) begin : g_tail
				assign next_e = '0;
			end else begin : g_mid
				assign next_e = cell_entry[g+1];
			end

			sdtq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.valid      (cell_valid[g]),
				.prev_entry (prev_e),
				.prev_take  (prev_t),
				.next_entry (next_e),
				.entry      (cell_entry[g]),
				.take       (cell_take[g])
			);
		end

		if (QUEUE_DEPTH > 1) begin : g_second
			assign second_entry = cell_entry[1];
			assign second_valid = cell_valid[1];
		end else begin : g_single
			assign second_entry = '0;
			assign second_valid = 1'b0;
		end
	endgenerate

	// the chain stays sorted, so only the head and its follower matter
	assign head_rel = cell_valid[0] && le_signed(cell_entry[0].deadline, time_q);
	assign next_rel = second_valid && le_signed(second_entry.deadline, time_q);

	always_comb begin
		ctl.insert              = (state_q == ST_DECIDE) && !passed && !full;
		ctl.shift               = (state_q == ST_RELEASE) && head_rel;
		ctl.new_entry.task_id   = task_q;
		ctl.new_entry.deadline  = deadline_q;
	end

	// payload of the accepted item
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q   <= command;
			task_q  <= task_id;
			value_q <= tick_value;
		end
		if (state_q == ST_CALC) begin
			deadline_q <= (cmd_q == CMD_DELAY) ? value_q + time_q : value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			time_q   <= '0;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					case (cmd_q)
						CMD_TICK: begin
							time_q  <= time_q + 1'b1;
							state_q <= ST_RELEASE;
						end
						CMD_GET_TIME: begin
							strobe_q <= 1'b1;
							state_q  <= ST_IDLE;
						end
						default: begin
							state_q <= ST_DECIDE;
						end
					endcase
				end
				ST_DECIDE: begin
					if (passed || full) begin
						strobe_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_RELEASE: begin
					if (head_rel) begin
						strobe_q <= 1'b1;
						count_q  <= count_q - 1'b1;
						if (!next_rel) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload: only meaningful while the strobe is high
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CALC: begin
				rtask_q  <= task_q;
				rvalue_q <= time_q;
				rfull_q  <= 1'b0;
				rlast_q  <= 1'b1;
			end
			ST_DECIDE: begin
				rtask_q  <= task_q;
				rvalue_q <= '0;
				rfull_q  <= !passed;
				rlast_q  <= 1'b1;
			end
			ST_RELEASE: begin
				rtask_q  <= cell_entry[0].task_id;
				rvalue_q <= '0;
				rfull_q  <= 1'b0;
				rlast_q  <= !next_rel;
			end
			default: begin
				rtask_q  <= rtask_q;
				rvalue_q <= rvalue_q;
				rfull_q  <= rfull_q;
				rlast_q  <= rlast_q;
			end
		endcase
	end

endmodule

// ===== design/sdtq_cell.sv =====
// ----------------------------------------------------------------------------
// sdtq_cell
// One slot of the sorted chain: holds an entry, opens a gap on insert and
// moves towards the head when the head is released.
// ----------------------------------------------------------------------------
module sdtq_cell (
	input  logic               clk,
	input  sdtq_pkg::cell_ctl_t ctl,
	input  logic               valid,
	input  sdtq_pkg::entry_t   prev_entry,
	input  logic               prev_take,
	input  sdtq_pkg::entry_t   next_entry,
	output sdtq_pkg::entry_t   entry,
	output logic               take
);
	import sdtq_pkg::*;

	entry_t entry_q;

	// new item goes at or before this slot: empty, or not later than ours
	assign take  = !valid || le_signed(ctl.new_entry.deadline, entry_q.deadline);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (prev_take) begin
				entry_q <= prev_entry;
			end else if (take) begin
				entry_q <= ctl.new_entry;
			end
		end else if (ctl.shift) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ===== design/sdtq_checker.sv =====
// ----------------------------------------------------------------------------
// sdtq_checker
// Port-level checks on the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module sdtq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [sdtq_pkg::CMD_W-1:0]  command,
	input logic [sdtq_pkg::TASK_W-1:0] task_id,
	input logic signed [sdtq_pkg::TIME_W-1:0] tick_value,
	input logic                        result_strobe,
	input logic [sdtq_pkg::TASK_W-1:0] reply_task,
	input logic signed [sdtq_pkg::TIME_W-1:0] reply_value,
	input logic                        rejected_full,
	input logic                        last_reply
);
	import sdtq_pkg::*;

	// an accepted item always shows busy in the cycle after it is taken
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted but block not busy");

	// wakeups of one tick come back to back until the last one
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_reply |=> result_strobe)
		else $error("wakeup burst broken before last item");

	// a refusal is a single reply
	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && rejected_full |-> last_reply && reply_value == '0)
		else $error("full refusal not a single reply");

	// only get time carries a value, and it is a single reply
	a_value_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && reply_value != '0 |-> last_reply && !rejected_full)
		else $error("time reply not a single reply");

endmodule

bind sorted_delay_timer_queue sdtq_checker u_sdtq_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted delay timer queue: drives tick, delay,
// absolute-delay and get-time commands over the start/busy handshake, keeps
// its own model of the time and the sorted wait list, and checks every
// strobed reply against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import sdtq_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 8;
	localparam int IDLE_PCT      = 27;
	localparam int DRAIN_TAIL    = 8;	// lets items with no reply finish
	localparam int STALL_LIMIT   = 2000;
	localparam int REPORT_LIMIT  = 10;

	// one predicted reply
	typedef struct packed {
		logic [TASK_W-1:0] who;
		logic [TIME_W-1:0] value;
		logic              full;
		logic              last;
	} reply_rec_t;

	logic                     clk;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	logic [CMD_W-1:0]         command    = CMD_GET_TIME;
	logic [TASK_W-1:0]        task_id    = '0;
	logic signed [TIME_W-1:0] tick_value = '0;
	logic                     busy;
	logic                     result_strobe;
	logic [TASK_W-1:0]        reply_task;
	logic signed [TIME_W-1:0] reply_value;
	logic                     rejected_full;
	logic                     last_reply;

	// model state: time now and the deadline-sorted list of sleepers
	logic [TIME_W-1:0] model_time = '0;
	entry_t            waiting_tasks[$];
	reply_rec_t        expected_replies[$];

	int  fail_count  = 0;
	int  stall_count = 0;
	bit  idle_enable = 1'b1;

	sorted_delay_timer_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.task_id       (task_id),
		.tick_value    (tick_value),
		.result_strobe (result_strobe),
		.reply_task    (reply_task),
		.reply_value   (reply_value),
		.rejected_full (rejected_full),
		.last_reply    (last_reply)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	function automatic bit due_by(input logic [TIME_W-1:0] deadline,
		input logic [TIME_W-1:0] now);
		return $signed(deadline) <= $signed(now);
	endfunction

	task automatic push_reply(input logic [TASK_W-1:0] who,
		input logic [TIME_W-1:0] value, input logic full, input logic last);
		reply_rec_t r;
		r.who   = who;
		r.value = value;
		r.full  = full;
		r.last  = last;
		expected_replies.push_back(r);
	endtask

	// Advance the model by one accepted item and queue the replies it causes.
	task automatic advance_timer_model(input logic [CMD_W-1:0] cmd,
		input logic [TASK_W-1:0] id, input logic [TIME_W-1:0] val);
		int                woken;
		int                pos;
		logic [TIME_W-1:0] deadline;
		entry_t            e;
		case (cmd)
			CMD_TICK: begin
				model_time = model_time + 1;
				woken = 0;
				while (woken < waiting_tasks.size() &&
					due_by(waiting_tasks[woken].deadline, model_time))
					woken++;
				for (int i = 0; i < woken; i++)
					push_reply(waiting_tasks[i].task_id, '0, 1'b0, i == woken - 1);
				repeat (woken) void'(waiting_tasks.pop_front());
			end
			CMD_GET_TIME: begin
				push_reply(id, model_time, 1'b0, 1'b1);
			end
			default: begin
				deadline = (cmd == CMD_DELAY) ? val + model_time : val;
				if (due_by(deadline, model_time))
					push_reply(id, '0, 1'b0, 1'b1);
				else if (waiting_tasks.size() >= QUEUE_DEPTH)
					push_reply(id, '0, 1'b1, 1'b1);
				else begin
					// behind smaller deadlines, ahead of equal ones
					pos = 0;
					while (pos < waiting_tasks.size() &&
						!due_by(deadline, waiting_tasks[pos].deadline))
						pos++;
					e.task_id  = id;
					e.deadline = deadline;
					waiting_tasks.insert(pos, e);
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Present one item and hold it until the block takes it. start is left
	// high on acceptance so back-to-back items need no extra edge; an idle
	// gap or a drain lowers it.
	task automatic send_item(input logic [CMD_W-1:0] cmd,
		input logic [TASK_W-1:0] id, input logic [TIME_W-1:0] val);
		if (idle_enable && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
		end
		start      <= 1'b1;
		command    <= cmd;
		task_id    <= id;
		tick_value <= val;
		do @(posedge clk); while (busy);
		advance_timer_model(cmd, id, val);
	endtask

	// Stop sending, wait for every predicted reply, then let the pipe settle
	// so that items with no reply are finished too.
	task automatic drain_replies();
		start <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Replies that come at once (get time, deadlines at or before now, relative
	// sums that wrap negative, extreme task ids) and a tick that wakes nobody.
	task automatic test_immediate_replies();
		send_item(CMD_GET_TIME, 7'd0,   32'h0000_0000);
		send_item(CMD_UNTIL,    7'd127, 32'h0000_0000);	// equal to now
		send_item(CMD_DELAY,    7'd1,   32'h0000_0000);
		send_item(CMD_DELAY,    7'd2,   32'hFFFF_FFFB);	// negative delay
		send_item(CMD_UNTIL,    7'd3,   32'h8000_0000);	// most negative
		send_item(CMD_TICK,     7'd4,   32'hFFFF_FFFF);	// wakes nobody
		send_item(CMD_DELAY,    7'd5,   32'h7FFF_FFFF);	// sum wraps negative
		send_item(CMD_GET_TIME, 7'd127, 32'hFFFF_FFFF);
		drain_replies();
	endtask

	// Ordering on wake-up: equal deadlines go newest first, one task may
	// sleep twice, and a tick can release several in one go.
	task automatic test_wake_order();
		send_item(CMD_DELAY,    7'd10,  32'd3);
		send_item(CMD_DELAY,    7'd11,  32'd3);
		send_item(CMD_UNTIL,    7'd12,  model_time + 32'd2);
		send_item(CMD_DELAY,    7'd10,  32'd3);
		send_item(CMD_DELAY,    7'd127, 32'd1);
		send_item(CMD_DELAY,    7'd0,   32'd5);
		send_item(CMD_TICK,     7'd0,   32'd0);
		send_item(CMD_TICK,     7'd0,   32'd0);
		send_item(CMD_GET_TIME, 7'd9,   32'd0);
		send_item(CMD_TICK,     7'd0,   32'd0);
		send_item(CMD_TICK,     7'd0,   32'd0);
		send_item(CMD_TICK,     7'd0,   32'd0);
		drain_replies();
	endtask

	// Fill every slot with the same deadline, bounce further delays, and
	// release the lot with one tick.
	task automatic test_queue_full();
		while (waiting_tasks.size() < QUEUE_DEPTH)
			send_item(CMD_DELAY, 7'($urandom_range(0, 127)), 32'd1);
		send_item(CMD_DELAY,    7'd100, 32'd5);			// refused, full
		send_item(CMD_UNTIL,    7'd101, 32'h7FFF_FFFF);	// refused, full
		send_item(CMD_UNTIL,    7'd102, model_time);	// passed beats full
		send_item(CMD_GET_TIME, 7'd103, 32'd0);
		send_item(CMD_TICK,     7'd0,   32'd0);			// 64 wake-ups
		send_item(CMD_TICK,     7'd0,   32'd0);
		drain_replies();
	endtask

	// Deadlines at the top of the range never come due in this run; a short delay beside them does.
	task automatic test_far_deadlines();
		send_item(CMD_UNTIL,    7'd20, 32'h7FFF_FFFF);
		send_item(CMD_DELAY,    7'd21, 32'h7FFF_FFF0);
		send_item(CMD_DELAY,    7'd22, 32'd2);
		send_item(CMD_TICK,     7'd0,  32'd0);
		send_item(CMD_TICK,     7'd0,  32'd0);
		drain_replies();
	endtask

	// Mixed traffic, mostly short delays that will come due, with a little
	// noise of full-range values.
	task automatic test_random_traffic(input int count);
		int                pick;
		logic [CMD_W-1:0]  cmd;
		logic [TIME_W-1:0] val;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)      cmd = CMD_TICK;
			else if (pick < 70) cmd = CMD_DELAY;
			else if (pick < 88) cmd = CMD_UNTIL;
			else                cmd = CMD_GET_TIME;
			if ($urandom_range(0, 99) < 6 || cmd == CMD_TICK || cmd == CMD_GET_TIME)
				val = $urandom;
			else if (cmd == CMD_DELAY)
				val = $urandom_range(0, 40);
			else
				val = model_time + $urandom_range(0, 48) - 32'd8;
			send_item(cmd, 7'($urandom_range(0, 127)), val);
		end
	endtask

	// ------------------------------------------------------------------
	// Reply checking: every strobe is taken, there is no back-pressure
	// ------------------------------------------------------------------

	task automatic report_failure(input string what);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin : check_replies
		reply_rec_t want;
		if (arst_n && result_strobe) begin
			if (expected_replies.size() == 0)
				report_failure($sformatf("unexpected reply: task %0d value %0h full %0b last %0b",
					reply_task, reply_value, rejected_full, last_reply));
			else begin
				want = expected_replies.pop_front();
				if (reply_task !== want.who || reply_value !== want.value ||
					rejected_full !== want.full || last_reply !== want.last)
					report_failure($sformatf({"reply mismatch: task %0d/%0d ",
						"value %0h/%0h full %0b/%0b last %0b/%0b (exp/got)"},
						want.who, reply_task, want.value, reply_value,
						want.full, rejected_full, want.last, last_reply));
			end
		end
	end

	// Watchdog: any edge with an accepted item or a reply counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe)
			stall_count <= 0;
		else if (stall_count >= STALL_LIMIT) begin
			$display("sorted_delay_timer_queue regression: fail");
			$finish;
		end else
			stall_count <= stall_count + 1;
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_immediate_replies();
		test_wake_order();
		test_queue_full();
		test_far_deadlines();

		test_random_traffic(140);
		drain_replies();			// hold off until everything is back
		idle_enable = 1'b0;		// back-to-back stretch
		test_random_traffic(100);
		idle_enable = 1'b1;
		test_random_traffic(95);
		drain_replies();

		if (fail_count == 0 && expected_replies.size() == 0)
			$display("sorted_delay_timer_queue regression: pass");
		else
			$display("sorted_delay_timer_queue regression: fail");
		$finish;
	end

endmodule
